// File: rtl/core/dpf_pkg.sv
// ----------------------------------------------------------------------------
// Dipole potential/force package
// Shared constants, widths and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package dpf_pkg;

  // Number of position axes in use (1 to 3).
  localparam int unsigned AXES = 3;

  // Width of the shared compare/subtract unit.
  localparam int unsigned SUB_W = 192;

  // Iteration bounds of the sequencer.
  localparam logic [5:0] SQRT_LAST = 6'd31;
  localparam logic [5:0] SQ_LAST   = 6'd2;
  localparam logic [5:0] GRAD_K    = 6'd32;
  localparam logic [5:0] POT_K     = 6'd48;
  localparam logic [2:0] MUL_TOP   = 3'd4;
  localparam logic [1:0] RND_Q3    = 2'd1;
  localparam logic [1:0] RND_Q5    = 2'd3;

  // Target code for the potential division (gradient axes are 0..2).
  localparam logic [1:0] AX_POT = 2'd3;

  localparam logic [47:0] SUM_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SUM_MIN = 48'h8000_0000_0000;
  localparam logic [31:0] STRENGTH_RST = 32'h0001_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/dpf_if.sv
// ----------------------------------------------------------------------------
// Dipole potential/force channels
// Valid/ready interfaces for particle requests and force results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpf_particle_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic        last_particle;

  modport source (output valid, pos_x, pos_y, pos_z, last_particle, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, last_particle, output ready);
endinterface

interface dpf_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] grad_x;
  logic [31:0] grad_y;
  logic [31:0] grad_z;
  logic [47:0] potential_sum;
  logic        set_done;
  logic        range_fault;

  modport source (output valid, grad_x, grad_y, grad_z, potential_sum, set_done,
                  range_fault, input ready);
  modport sink   (input valid, grad_x, grad_y, grad_z, potential_sum, set_done,
                  range_fault, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dpf_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32x32 multiplier used by every product step of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module dpf_mul import dpf_pkg::*; (
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p
);

  assign p = {32'b0, a} * {32'b0, b};

endmodule

`default_nettype wire

// File: rtl/core/dpf_sub.sv
// ----------------------------------------------------------------------------
// Shared trial subtractor
// Wide compare and subtract used by the square root and the divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module dpf_sub import dpf_pkg::*; (
  input  wire logic [SUB_W-1:0] a,
  input  wire logic [SUB_W-1:0] b,
  output logic      [SUB_W-1:0] diff,
  output logic                  ge
);

  logic [SUB_W:0] full;

  assign full = {1'b0, a} - {1'b0, b};
  assign diff = full[SUB_W-1:0];
  assign ge   = ~full[SUB_W];

endmodule

`default_nettype wire

// File: rtl/core/dipole_potential_force_core.sv
// ----------------------------------------------------------------------------
// Dipole potential and force core
// Inverse-cube dipole gradient and running potential sum on a shared multiplier and subtractor.
// ----------------------------------------------------------------------------
// Each request on the particle channel carries a Q16.16 distance vector and a
// last_particle mark. The core returns one result per request on the result
// channel: the gradient -3*S*x/r^5 per axis, the running potential sum of
// S/r^3 including this particle, set_done and range_fault.
// The strength S is written through cfg_we/cfg_wdata; the user must write it
// only while the core is idle, as the core does not enforce this. A request
// runs through the squares, the square root, the forming of r^3 and r^5 on
// the shared 32x32 multiplier, one division per gradient axis in use and one
// for the potential on the shared wide subtractor, with a step each to accept
// and to finish. A zero distance skips the root and the divisions.
// The core takes no new request until the current one is finished.
// The result sits in an output register; when the receiver stalls the core
// finishes the next request and then holds in its final step until the
// previous result is taken. Reset empties the pipeline, clears the potential
// sum and loads a strength of 1.0. The sum clears after a result whose
// last_particle mark was set.
// ----------------------------------------------------------------------------
`default_nettype none

module dipole_potential_force_core import dpf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  dpf_particle_if.sink     particle,
  dpf_result_if.source     result
);

  state_t state, state_next;

  logic [31:0]      strength;
  logic [47:0]      acc_pot;
  logic             out_valid;

  // Per-request working registers.
  logic [31:0]      pos_mag [3];
  logic [2:0]       pos_neg;
  logic             last_q;
  logic [63:0]      s;
  logic [63:0]      res;
  logic [63:0]      bitv;
  logic [5:0]       cnt;
  logic [159:0]     m_a;
  logic [159:0]     m_acc;
  logic [2:0]       mw;
  logic [1:0]       mround;
  logic [95:0]      d3;
  logic [159:0]     d5;
  logic [SUB_W-1:0] rem;
  logic [SUB_W-1:0] dvs;
  logic [48:0]      quo;
  logic             first;
  logic [1:0]       ax;
  logic [31:0]      grad [3];
  logic [47:0]      contrib;
  logic             fault;

  // Output register.
  logic [31:0]      o_grad [3];
  logic [47:0]      o_sum;
  logic             o_done;
  logic             o_fault;

  // Strength magnitude and sign.
  logic [31:0] smag;
  logic        sneg;
  assign sneg = strength[31];
  assign smag = sneg ? (32'd0 - strength) : strength;

  // Shared multiplier operands.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQ: begin
        mul_a = pos_mag[cnt[1:0]];
        mul_b = pos_mag[cnt[1:0]];
      end
      ST_MUL: begin
        mul_a = m_a[{mw, 5'b0} +: 32];
        mul_b = res[31:0];
      end
      ST_PREP: begin
        if (ax != AX_POT) begin
          mul_a = smag;
          mul_b = pos_mag[ax];
        end
      end
      default: begin
      end
    endcase
  end

  dpf_mul u_mul (.a(mul_a), .b(mul_b), .p(mul_p));

  // Shared subtractor operands.
  logic [SUB_W-1:0] sub_a, sub_b, sub_d;
  logic             sub_ge;

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state)
      ST_SQRT: begin
        sub_a = {128'b0, s};
        sub_b = {128'b0, res | bitv};
      end
      ST_DIV: begin
        sub_a = rem;
        sub_b = dvs;
      end
      default: begin
      end
    endcase
  end

  dpf_sub u_sub (.a(sub_a), .b(sub_b), .diff(sub_d), .ge(sub_ge));

  // Derived values of the current step.
  logic [63:0]  s_next;
  logic [63:0]  res_next;
  logic [159:0] m_acc_next;
  logic [65:0]  p3;
  logic         div_ovf;
  logic         div_done;
  logic [48:0]  quo_next;
  logic [32:0]  g;
  logic [48:0]  v;
  logic [48:0]  sum49;

  assign s_next     = s + mul_p;
  assign res_next   = sub_ge ? ((res >> 1) | bitv) : (res >> 1);
  assign m_acc_next = {m_acc[127:0], 32'b0} + {96'b0, mul_p};
  assign p3         = {1'b0, mul_p, 1'b0} + {2'b0, mul_p};
  assign div_ovf    = first & sub_ge;
  assign div_done   = div_ovf | (cnt == 6'd0);
  assign quo_next   = {quo[47:0], sub_ge};
  assign g          = {1'b0, quo_next[31:0]};
  assign v          = {1'b0, quo_next[47:0]};
  assign sum49      = {acc_pot[47], acc_pot} + {contrib[47], contrib};

  logic fin_go;
  assign fin_go = (state == ST_FIN) && (!out_valid || result.ready);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (particle.valid) state_next = ST_SQ;
      ST_SQ: begin
        if (cnt == SQ_LAST) state_next = (s_next == 64'd0) ? ST_FIN : ST_SQRT;
      end
      ST_SQRT: if (cnt == SQRT_LAST) state_next = ST_MUL;
      ST_MUL: if (mw == 3'd0 && mround == RND_Q5) state_next = ST_PREP;
      ST_PREP: begin
        if (ax != AX_POT && 32'(ax) >= AXES) state_next = ST_PREP;
        else state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_next = (ax == AX_POT) ? ST_FIN : ST_PREP;
      end
      ST_FIN: if (fin_go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      strength  <= STRENGTH_RST;
      acc_pot   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) strength <= cfg_wdata;
      if (fin_go) begin
        out_valid <= 1'b1;
        if (last_q) acc_pot <= '0;
        else if (sum49[48] != sum49[47]) acc_pot <= sum49[48] ? SUM_MIN : SUM_MAX;
        else acc_pot <= sum49[47:0];
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (particle.valid) begin
          pos_mag[0] <= particle.pos_x[31] ? (32'd0 - particle.pos_x) : particle.pos_x;
          pos_mag[1] <= (AXES < 2) ? 32'd0 :
                        (particle.pos_y[31] ? (32'd0 - particle.pos_y) : particle.pos_y);
          pos_mag[2] <= (AXES < 3) ? 32'd0 :
                        (particle.pos_z[31] ? (32'd0 - particle.pos_z) : particle.pos_z);
          pos_neg    <= {particle.pos_z[31] & (AXES >= 3),
                         particle.pos_y[31] & (AXES >= 2), particle.pos_x[31]};
          last_q     <= particle.last_particle;
          s          <= '0;
          cnt        <= '0;
          fault      <= 1'b0;
          grad[0]    <= '0;
          grad[1]    <= '0;
          grad[2]    <= '0;
        end
      end
      ST_SQ: begin
        s   <= s_next;
        cnt <= cnt + 6'd1;
        if (cnt == SQ_LAST) begin
          cnt  <= '0;
          res  <= '0;
          bitv <= 64'h4000_0000_0000_0000;
          if (s_next == 64'd0) begin
            // Zero distance: the potential term saturates by the sign of S, or is zero for a zero S.
            fault   <= 1'b1;
            contrib <= sneg ? SUM_MIN : ((smag != 32'd0) ? SUM_MAX : 48'd0);
          end
        end
      end
      ST_SQRT: begin
        if (sub_ge) s <= sub_d[63:0];
        res  <= res_next;
        bitv <= bitv >> 2;
        cnt  <= cnt + 6'd1;
        if (cnt == SQRT_LAST) begin
          m_a    <= {128'b0, res_next[31:0]};
          m_acc  <= '0;
          mw     <= MUL_TOP;
          mround <= '0;
        end
      end
      ST_MUL: begin
        // Multiplicand times r, one 32-bit word per cycle from the top down.
        m_acc <= m_acc_next;
        mw    <= mw - 3'd1;
        if (mw == 3'd0) begin
          m_a    <= m_acc_next;
          m_acc  <= '0;
          mw     <= MUL_TOP;
          mround <= mround + 2'd1;
          if (mround == RND_Q3) d3 <= m_acc_next[95:0];
          if (mround == RND_Q5) d5 <= m_acc_next;
          ax <= '0;
        end
      end
      ST_PREP: begin
        quo   <= '0;
        first <= 1'b1;
        if (ax == AX_POT) begin
          rem <= {96'b0, smag, 64'b0} >> 16;
          dvs <= {48'b0, d3, 48'b0};
          cnt <= POT_K;
        end else if (32'(ax) >= AXES) begin
          ax <= ax + 2'd1;
        end else begin
          rem <= {62'b0, p3, 64'b0};
          dvs <= {d5, 32'b0};
          cnt <= GRAD_K;
        end
      end
      ST_DIV: begin
        first <= 1'b0;
        if (sub_ge) rem <= sub_d;
        dvs <= dvs >> 1;
        quo <= quo_next;
        cnt <= cnt - 6'd1;
        if (div_done) begin
          ax <= ax + 2'd1;
          if (ax == AX_POT) begin
            if (sneg) begin
              if (div_ovf || v > {1'b0, SUM_MIN}) begin
                contrib <= SUM_MIN;
                fault   <= 1'b1;
              end else begin
                contrib <= 48'd0 - v[47:0];
              end
            end else begin
              if (div_ovf || v[47]) begin
                contrib <= SUM_MAX;
                fault   <= 1'b1;
              end else begin
                contrib <= v[47:0];
              end
            end
          end else begin
            if (sneg == pos_neg[ax]) begin
              if (div_ovf || g > 33'h0_8000_0000) begin
                grad[ax] <= 32'h8000_0000;
                fault    <= 1'b1;
              end else begin
                grad[ax] <= 32'd0 - g[31:0];
              end
            end else begin
              if (div_ovf || g[31]) begin
                grad[ax] <= 32'h7FFF_FFFF;
                fault    <= 1'b1;
              end else begin
                grad[ax] <= g[31:0];
              end
            end
          end
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          o_grad[0] <= grad[0];
          o_grad[1] <= grad[1];
          o_grad[2] <= grad[2];
          o_done    <= last_q;
          if (sum49[48] != sum49[47]) begin
            o_sum   <= sum49[48] ? SUM_MIN : SUM_MAX;
            o_fault <= 1'b1;
          end else begin
            o_sum   <= sum49[47:0];
            o_fault <= fault;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign particle.ready       = (state == ST_IDLE);
  assign result.valid         = out_valid;
  assign result.grad_x        = o_grad[0];
  assign result.grad_y        = o_grad[1];
  assign result.grad_z        = o_grad[2];
  assign result.potential_sum = o_sum;
  assign result.set_done      = o_done;
  assign result.range_fault   = o_fault;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    particle.valid && particle.ready |=> !particle.ready)
    else $error("core ready in the cycle after accepting a request");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == ST_FIN))
    else $error("result raised outside the final step");

  a_sum_clears: assert property (@(posedge clk) disable iff (rst)
    fin_go && last_q |=> acc_pot == 48'd0)
    else $error("potential sum not cleared after the last particle");

  a_sqrt_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SQRT |-> cnt <= SQRT_LAST)
    else $error("square root step count out of range");
`endif

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dipole potential and force core testbench
// Checks gradients, running potential sums, set_done and fault flags against a
// built-in bit-exact predictor under random valid/ready idling.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import dpf_pkg::*;

  typedef struct packed {
    logic [31:0] grad_x;
    logic [31:0] grad_y;
    logic [31:0] grad_z;
    logic [47:0] potential_sum;
    logic        set_done;
    logic        range_fault;
  } force_t;

  // Scoreboard: predicts the result of each accepted request, in order, and
  // compares the results that come back against those predictions.
  class force_scoreboard;
    logic [31:0]  strength;
    longint       accumulator;
    force_t       expected_q[$];
    int           errors;

    function new();
      strength    = STRENGTH_RST;
      accumulator = 0;
      errors      = 0;
    endfunction

    // Work out the result of one request and update the running sum.
    function void note_request(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                               logic last);
      longint       sv, pos[3], grad[3], contrib, total;
      bit [63:0]    smag, mag[3], s, rem, root, bitv;
      bit [191:0]   q, d3, d5, num, quo;
      bit           fault;
      force_t       e;
      sv      = longint'($signed(strength));
      smag    = sv < 0 ? -sv : sv;
      pos[0]  = longint'($signed(px));
      pos[1]  = AXES > 1 ? longint'($signed(py)) : 0;
      pos[2]  = AXES > 2 ? longint'($signed(pz)) : 0;
      s       = 0;
      fault   = 0;
      for (int a = 0; a < 3; a++) begin
        mag[a]  = pos[a] < 0 ? -pos[a] : pos[a];
        s       = s + mag[a] * mag[a];
        grad[a] = 0;
      end
      if (s == 0) begin
        // Zero distance: no gradient, the contribution pins to the sign limit, or is zero for a zero strength.
        fault   = 1;
        contrib = sv > 0 ? longint'($signed(SUM_MAX)) :
                  (sv < 0 ? longint'($signed(SUM_MIN)) : 0);
      end else begin
        // Integer square root, bit by bit, giving floor(sqrt(s)).
        rem  = s;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
          if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
          end else begin
            root = root >> 1;
          end
          bitv = bitv >> 2;
        end
        q  = 192'(root);
        d3 = q * q * q;
        d5 = d3 * q * q;
        for (int a = 0; a < 3 && a < AXES; a++) begin
          num = 192'(3 * smag * mag[a]) << 64;
          quo = num / d5;
          if ((sv < 0) == (pos[a] < 0)) begin
            if (quo > 192'h8000_0000) begin
              quo   = 192'h8000_0000;
              fault = 1;
            end
            grad[a] = -longint'(quo[63:0]);
          end else begin
            if (quo > 192'h7FFF_FFFF) begin
              quo   = 192'h7FFF_FFFF;
              fault = 1;
            end
            grad[a] = longint'(quo[63:0]);
          end
        end
        num = 192'(smag) << 48;
        quo = num / d3;
        if (sv < 0) begin
          if (quo > (192'd1 << 47)) begin
            quo   = 192'd1 << 47;
            fault = 1;
          end
          contrib = -longint'(quo[63:0]);
        end else begin
          if (quo > 192'(SUM_MAX)) begin
            quo   = 192'(SUM_MAX);
            fault = 1;
          end
          contrib = longint'(quo[63:0]);
        end
      end
      total = accumulator + contrib;
      if (total > longint'($signed(SUM_MAX))) begin
        total = longint'($signed(SUM_MAX));
        fault = 1;
      end
      if (total < longint'($signed(SUM_MIN))) begin
        total = longint'($signed(SUM_MIN));
        fault = 1;
      end
      accumulator     = last ? 0 : total;
      e.grad_x        = grad[0][31:0];
      e.grad_y        = grad[1][31:0];
      e.grad_z        = grad[2][31:0];
      e.potential_sum = total[47:0];
      e.set_done      = last;
      e.range_fault   = fault;
      expected_q.push_back(e);
    endfunction

    // Compare one accepted result with the oldest prediction.
    function void check_result(force_t act);
      force_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no request outstanding: %h", $time, act);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (act.grad_x !== e.grad_x) begin
        $display("%0t: grad_x expected %h actual %h", $time, e.grad_x, act.grad_x);
        errors++;
      end
      if (act.grad_y !== e.grad_y) begin
        $display("%0t: grad_y expected %h actual %h", $time, e.grad_y, act.grad_y);
        errors++;
      end
      if (act.grad_z !== e.grad_z) begin
        $display("%0t: grad_z expected %h actual %h", $time, e.grad_z, act.grad_z);
        errors++;
      end
      if (act.potential_sum !== e.potential_sum) begin
        $display("%0t: potential_sum expected %h actual %h", $time,
                 e.potential_sum, act.potential_sum);
        errors++;
      end
      if (act.set_done !== e.set_done) begin
        $display("%0t: set_done expected %b actual %b", $time, e.set_done, act.set_done);
        errors++;
      end
      if (act.range_fault !== e.range_fault) begin
        $display("%0t: range_fault expected %b actual %b", $time,
                 e.range_fault, act.range_fault);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [31:0] cfg_wdata = '0;
  int          cycles = 0;

  // Generous bound: room for every request and the idle gaps on each side,
  // taken several times over.
  localparam int CYCLE_LIMIT = 3_000_000;

  dpf_particle_if particle ();
  dpf_result_if   result ();

  dipole_potential_force_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .particle (particle.sink),
    .result   (result.source)
  );

  force_scoreboard sb = new();

  always #10 clk = ~clk;

  initial begin
    particle.valid         = 0;
    particle.pos_x         = '0;
    particle.pos_y         = '0;
    particle.pos_z         = '0;
    particle.last_particle = 0;
    result.ready           = 0;
  end

  // Watchdog: a hung core or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("dipole_potential_force_core: mismatch");
      $finish;
    end
  end

  // Send one request after an idle gap. Valid is only lowered when there is
  // a gap, so back-to-back requests never see valid dropped and raised in
  // the same time step.
  task automatic send_request(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic last);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      particle.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    particle.valid         <= 1;
    particle.pos_x         <= px;
    particle.pos_y         <= py;
    particle.pos_z         <= pz;
    particle.last_particle <= last;
    do @(posedge clk); while (!particle.ready);
    sb.note_request(px, py, pz, last);
  endtask

  // Write the strength register once all outstanding results are back.
  task automatic write_strength(logic [31:0] value);
    particle.valid <= 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    cfg_we    <= 1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 0;
    sb.strength = value;
  endtask

  // A coordinate at a random scale, so that distances span the range where
  // gradients saturate, stay exact, or vanish.
  function automatic logic [31:0] random_coord();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0:       v = $urandom;
      1:       v = '0;
      default: v = $urandom >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // Receiver: random stall before each result, with runs of no stall.
  initial begin
    int     gap;
    force_t act;
    @(negedge rst);
    forever begin
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        result.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      result.ready <= 1;
      do @(posedge clk); while (!result.valid);
      act.grad_x        = result.grad_x;
      act.grad_y        = result.grad_y;
      act.grad_z        = result.grad_z;
      act.potential_sum = result.potential_sum;
      act.set_done      = result.set_done;
      act.range_fault   = result.range_fault;
      sb.check_result(act);
    end
  end

  // Main sequence: reset, a directed set of requests, then random phases,
  // each under a different strength setting.
  initial begin
    logic [31:0] strengths[6];
    strengths[0] = STRENGTH_RST;
    strengths[1] = 32'h7FFF_FFFF;
    strengths[2] = 32'h8000_0000;
    strengths[3] = 32'h0000_0000;
    strengths[4] = 32'hFFFF_0000;
    strengths[5] = $urandom;

    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed requests at the reset strength.
    send_request(32'h0, 32'h0, 32'h0, 0);                        // zero distance
    send_request(32'h0001_0000, 32'h0, 32'h0, 0);                // unit distance
    send_request(32'h0, 32'hFFFF_0000, 32'h0, 0);
    send_request(32'h0, 32'h0, 32'h0002_0000, 1);                // closes a set
    send_request(32'h0000_0001, 32'h0, 32'h0, 0);                // tiny: saturates
    send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1);
    send_request(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 0);
    send_request(32'h0000_4000, 32'hFFFF_C000, 32'h0000_4000, 0);
    send_request(32'h0, 32'h0, 32'h0, 1);
    send_request(32'h0010_0000, 32'h0, 32'h0, 0);
    // Many tiny distances in one set drive the sum to its limit.
    for (int i = 0; i < 6; i++)
      send_request(32'h0000_0001, 32'h0, 32'h0, i == 5);

    // Zero strength and its extremes on the zero-distance case too.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_strength(strengths[ph]);
      if (ph > 0) begin
        send_request(32'h0, 32'h0, 32'h0, 0);
        send_request(32'h0000_0100, 32'h0, 32'hFFFF_FF00, 0);
      end
      for (int i = 0; i < 320; i++)
        send_request(random_coord(), random_coord(), random_coord(),
                     $urandom_range(0, 7) == 0);
    end
    write_strength(STRENGTH_RST);
    send_request(32'h0003_0000, 32'h0004_0000, 32'h0, 1);
    particle.valid <= 0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("dipole_potential_force_core: match");
    end else begin
      $display("dipole_potential_force_core: mismatch");
    end
    $finish;
  end
endmodule

`default_nettype wire
